@@ rtl/core/stable_bounded_priority_queue_core_defines.svh @@
// assertion macros for the stable bounded priority queue checker
// expects clk and rst_n in the scope of use
`ifndef STABLE_BOUNDED_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define STABLE_BOUNDED_PRIORITY_QUEUE_CORE_DEFINES_SVH

// same-cycle implication, off during reset
`define SBPQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbpq check failed");

// next-cycle implication, off during reset
`define SBPQ_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbpq check failed");

// next-cycle implication, always on
`define SBPQ_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("sbpq check failed");

`endif

@@ rtl/core/sbpq_pkg.sv @@
// types and constants of the stable bounded priority queue
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package sbpq_pkg;

  localparam int QUEUE_DEPTH_DEF   = 16;
  localparam int PRIORITY_BITS_DEF = 8;
  localparam int PRI_FIELD_W       = 8;
  localparam int CAP_W             = 5;
  localparam int OCC_W             = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam logic [CAP_W-1:0] CAP_MIN   = 5'd1;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_POP    = 1'b1;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_POPPED   = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic                   command;
    logic [15:0]            client_id;
    logic [31:0]            request_handle;
    logic [PRI_FIELD_W-1:0] priority_req;
    logic [15:0]            delay_seconds;
  } in_word_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [15:0]            out_client_id;
    logic [31:0]            out_request_handle;
    logic [PRI_FIELD_W-1:0] out_priority;
    logic [15:0]            out_delay_seconds;
    logic [OCC_W-1:0]       occupancy;
  } out_word_t;

  // entry payload held in each cell, priority kept apart
  typedef struct packed {
    logic [15:0] client;
    logic [31:0] handle;
    logic [15:0] delay;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctl_t;

endpackage
`default_nettype wire

@@ rtl/core/sbpq_cell.sv @@
// one slot of the sorted shift row: holds an entry and its priority
// depends on sbpq_pkg
`timescale 1ns / 1ps
`default_nettype none
module sbpq_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5,
  parameter int PRI_W = 8
) (
  input  wire                      clk,
  input  sbpq_pkg::cell_ctl_t      ctl,
  input  wire  [CNT_W-1:0]         count,
  input  sbpq_pkg::entry_t         new_pay,
  input  wire  [PRI_W-1:0]         new_pri,
  input  sbpq_pkg::entry_t         left_pay,
  input  wire  [PRI_W-1:0]         left_pri,
  input  wire                      left_ge,
  input  sbpq_pkg::entry_t         right_pay,
  input  wire  [PRI_W-1:0]         right_pri,
  output sbpq_pkg::entry_t         pay,
  output logic [PRI_W-1:0]         pri,
  output logic                     ge
);
  import sbpq_pkg::*;

  entry_t           pay_r, pay_nxt;
  logic [PRI_W-1:0] pri_r, pri_nxt;
  logic             occupied;

  assign occupied = CNT_W'(IDX) < count;
  assign ge       = occupied && (pri_r >= new_pri);
  assign pay      = pay_r;
  assign pri      = pri_r;

  always_comb begin
    pay_nxt = pay_r;
    pri_nxt = pri_r;
    if (ctl.ins) begin
      if (!left_ge) begin
        pay_nxt = left_pay;
        pri_nxt = left_pri;
      end else if (!ge) begin
        pay_nxt = new_pay;
        pri_nxt = new_pri;
      end
    end else if (ctl.pop) begin
      pay_nxt = right_pay;
      pri_nxt = right_pri;
    end
  end

  always_ff @(posedge clk) begin
    pay_r <= pay_nxt;
    pri_r <= pri_nxt;
  end

endmodule
`default_nettype wire

@@ rtl/core/stable_bounded_priority_queue_core.sv @@
// top level of the stable bounded priority queue: control, row of cells, result register
// depends on sbpq_pkg and sbpq_cell
//
// Use: a command word enters on in_valid/in_ready. An insert places the entry behind
// every held entry of equal or higher priority; a pop returns the head entry. Each
// accepted word yields exactly one result word on out_valid/out_ready, carrying a
// status (inserted, popped, pop on empty, insert rejected full) and the occupancy
// after the step. Entry fields in the result are zero unless an entry was popped.
// The result is registered and appears the cycle after acceptance. One word per cycle
// is accepted while the receiver takes results. Cells from the insertion point on shift
// toward the tail on insert; every cell shifts toward the head on pop.
// cfg_we writes the capacity limit (0 acts as 1, values above the depth act as the
// depth) and should only be used while no word is in flight.
// Reset (synchronous, rst_n low) empties the queue, sets the limit to 16 and drops
// any pending result. While the receiver stalls, the result register holds and
// in_ready stays low until the result is taken.
`timescale 1ns / 1ps
`default_nettype none
module stable_bounded_priority_queue_core #(
  parameter int QUEUE_DEPTH   = sbpq_pkg::QUEUE_DEPTH_DEF,
  parameter int PRIORITY_BITS = sbpq_pkg::PRIORITY_BITS_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  output logic                            in_ready,
  input  sbpq_pkg::in_word_t              in_word,
  output logic                            out_valid,
  input  wire                             out_ready,
  output sbpq_pkg::out_word_t             out_word,
  input  wire                             cfg_we,
  input  wire  [sbpq_pkg::CAP_W-1:0]      cfg_wdata
);
  import sbpq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int PRI_W = (PRIORITY_BITS < PRI_FIELD_W) ? PRIORITY_BITS : PRI_FIELD_W;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

  logic [CAP_W-1:0] limit_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  out_word_t        out_word_r, out_word_nxt;

  logic             accept, is_pop, full, empty, ins_do, pop_do;
  logic [CAP_W-1:0] lim_eff;
  cell_ctl_t        ctl;
  entry_t           new_pay;
  logic [PRI_W-1:0] new_pri;

  entry_t           pay_a [QUEUE_DEPTH];
  logic [PRI_W-1:0] pri_a [QUEUE_DEPTH];
  logic             ge_a  [QUEUE_DEPTH];

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign is_pop  = (in_word.command == CMD_POP);
  assign lim_eff = (limit_r == '0) ? CAP_MIN : limit_r;
  assign full    = (CMP_W'(count_r) >= CMP_W'(lim_eff)) || (count_r >= DEPTH_C);
  assign empty   = (count_r == '0);
  assign ins_do  = accept && !is_pop && !full;
  assign pop_do  = accept && is_pop && !empty;

  assign ctl.ins = ins_do;
  assign ctl.pop = pop_do;

  assign new_pay.client = in_word.client_id;
  assign new_pay.handle = in_word.request_handle;
  assign new_pay.delay  = in_word.delay_seconds;
  assign new_pri        = in_word.priority_req[PRI_W-1:0];

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      localparam int L = (gi == 0) ? 0 : gi - 1;
      localparam int R = (gi == QUEUE_DEPTH - 1) ? gi : gi + 1;
      logic left_ge;
      assign left_ge = (gi == 0) ? 1'b1 : ge_a[L];
      sbpq_cell #(
        .IDX   (gi),
        .CNT_W (CNT_W),
        .PRI_W (PRI_W)
      ) u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .count     (count_r),
        .new_pay   (new_pay),
        .new_pri   (new_pri),
        .left_pay  (pay_a[L]),
        .left_pri  (pri_a[L]),
        .left_ge   (left_ge),
        .right_pay (pay_a[R]),
        .right_pri (pri_a[R]),
        .pay       (pay_a[gi]),
        .pri       (pri_a[gi]),
        .ge        (ge_a[gi])
      );
    end
  endgenerate

  always_comb begin
    count_nxt = count_r;
    if (ins_do) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_do) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_comb begin
    out_word_nxt = '0;
    if (is_pop) begin
      out_word_nxt.status = empty ? ST_EMPTY : ST_POPPED;
      if (!empty) begin
        out_word_nxt.out_client_id      = pay_a[0].client;
        out_word_nxt.out_request_handle = pay_a[0].handle;
        out_word_nxt.out_priority       = PRI_FIELD_W'(pri_a[0]);
        out_word_nxt.out_delay_seconds  = pay_a[0].delay;
      end
    end else begin
      out_word_nxt.status = full ? ST_FULL : ST_INSERTED;
    end
    out_word_nxt.occupancy = OCC_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= CAP_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_word_r <= out_word_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/sbpq_checker.sv @@
// port-level checks of the stable bounded priority queue, bound to the top level
// depends on sbpq_pkg and stable_bounded_priority_queue_core_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "stable_bounded_priority_queue_core_defines.svh"
module sbpq_checker (
  input wire                        clk,
  input wire                        rst_n,
  input wire                        in_ready,
  input wire                        out_valid,
  input wire                        out_ready,
  input sbpq_pkg::out_word_t        out_word
);
  import sbpq_pkg::*;

  logic not_popped, fields_zero, empty_res;

  assign not_popped  = out_valid && (out_word.status != ST_POPPED);
  assign fields_zero = (out_word.out_client_id == '0) && (out_word.out_request_handle == '0) &&
                       (out_word.out_priority == '0) && (out_word.out_delay_seconds == '0);
  assign empty_res   = out_valid && (out_word.status == ST_EMPTY);

  `SBPQ_ASSERT_RST(a_reset_clears, !rst_n, !out_valid)
  `SBPQ_ASSERT_NXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(out_word))
  `SBPQ_ASSERT_IMP(a_idle_ready, !out_valid, in_ready)
  `SBPQ_ASSERT_IMP(a_zero_fields, not_popped, fields_zero)
  `SBPQ_ASSERT_IMP(a_empty_occ, empty_res, out_word.occupancy == '0)

endmodule

bind stable_bounded_priority_queue_core sbpq_checker u_sbpq_checker (.*);
`default_nettype wire

@@ dv/tb.sv @@
// testbench for stable_bounded_priority_queue_core: directed and random insert/pop traffic
// checked against a queue-based predictor; depends on sbpq_pkg and the core rtl
`timescale 1ns / 1ps
module tb;
  import sbpq_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int ITEMS_PER_PHASE = 212;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_word_t    in_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_word;
  logic        cfg_we = 1'b0;
  logic [CAP_W-1:0] cfg_wdata = '0;

  // predictor state
  in_word_t    held_entries[$];
  int          limit_reg = 16;
  out_word_t   expected_results[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int err_count = 0;
  int n_inserted = 0;
  int n_popped = 0;
  int n_empty = 0;
  int n_full = 0;

  stable_bounded_priority_queue_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  function automatic out_word_t predict_queue_step(in_word_t w);
    out_word_t r;
    int lim;
    int pos;
    r = '0;
    if (w.command == CMD_INSERT) begin
      lim = (limit_reg == 0) ? 1 : ((limit_reg > QUEUE_DEPTH_DEF) ? QUEUE_DEPTH_DEF : limit_reg);
      if (held_entries.size() >= lim) begin
        r.status = ST_FULL;
        n_full++;
      end else begin
        pos = 0;
        while (pos < held_entries.size() && held_entries[pos].priority_req >= w.priority_req)
          pos++;
        held_entries.insert(pos, w);
        r.status = ST_INSERTED;
        n_inserted++;
      end
    end else begin
      if (held_entries.size() == 0) begin
        r.status = ST_EMPTY;
        n_empty++;
      end else begin
        w = held_entries.pop_front();
        r.status             = ST_POPPED;
        r.out_client_id      = w.client_id;
        r.out_request_handle = w.request_handle;
        r.out_priority       = w.priority_req;
        r.out_delay_seconds  = w.delay_seconds;
        n_popped++;
      end
    end
    r.occupancy = OCC_W'(held_entries.size());
    return r;
  endfunction

  function automatic in_word_t make_word(logic cmd, logic [15:0] client, logic [31:0] handle,
                                         logic [7:0] pri, logic [15:0] delay);
    in_word_t w;
    w.command        = cmd;
    w.client_id      = client;
    w.request_handle = handle;
    w.priority_req   = pri;
    w.delay_seconds  = delay;
    return w;
  endfunction

  function automatic in_word_t random_word(logic cmd);
    logic [7:0] pri;
    case ($urandom_range(0, 3))
      0: pri = 8'($urandom_range(0, 3));
      1: pri = 8'($urandom_range(0, 255));
      2: pri = $urandom_range(0, 1) ? 8'hff : 8'h00;
      default: pri = 8'($urandom_range(100, 103));
    endcase
    return make_word(cmd, 16'($urandom), $urandom, pri, 16'($urandom));
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic check_result(input out_word_t got);
    out_word_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("result word %h with nothing pending", got));
    end else begin
      want = expected_results.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.out_client_id !== want.out_client_id)
        report_mismatch($sformatf("client got %h want %h",
                                  got.out_client_id, want.out_client_id));
      if (got.out_request_handle !== want.out_request_handle)
        report_mismatch($sformatf("handle got %h want %h",
                                  got.out_request_handle, want.out_request_handle));
      if (got.out_priority !== want.out_priority)
        report_mismatch($sformatf("priority got %0d want %0d",
                                  got.out_priority, want.out_priority));
      if (got.out_delay_seconds !== want.out_delay_seconds)
        report_mismatch($sformatf("delay got %h want %h",
                                  got.out_delay_seconds, want.out_delay_seconds));
      if (got.occupancy !== want.occupancy)
        report_mismatch($sformatf("occupancy got %0d want %0d",
                                  got.occupancy, want.occupancy));
    end
  endtask

  // result side: check each accepted word, stall at random
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result(out_word);
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("[stable_bounded_priority_queue_core] ERROR");
    $finish;
  end

  task automatic send_word(input in_word_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(predict_queue_step(w));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [CAP_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    limit_reg = int'(value);
  endtask

  task automatic set_idle_profile(input int sel);
    case (sel % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
      default: begin send_idle_pct = 29; recv_stall_pct = 29; end
    endcase
  endtask

  // reset limit, empty pop, field extremes, priority ties
  task automatic test_directed_extremes;
    send_word(make_word(CMD_POP, 16'hffff, 32'hffffffff, 8'hff, 16'hffff));
    send_word(make_word(CMD_INSERT, 16'h0000, 32'h00000000, 8'h00, 16'h0000));
    send_word(make_word(CMD_INSERT, 16'hffff, 32'hffffffff, 8'hff, 16'hffff));
    send_word(make_word(CMD_INSERT, 16'h1234, 32'h89abcdef, 8'hff, 16'h5a5a));
    send_word(make_word(CMD_INSERT, 16'h4321, 32'h76543210, 8'h00, 16'ha5a5));
    send_word(make_word(CMD_INSERT, 16'h00aa, 32'h55aa55aa, 8'h80, 16'h0f0f));
    repeat (5) send_word(make_word(CMD_POP, 16'h0, 32'h0, 8'h0, 16'h0));
    send_word(make_word(CMD_POP, 16'h0, 32'h0, 8'h0, 16'h0));
    drain();
  endtask

  // limit of zero, limit lowered under the held count
  task automatic test_limit_edges;
    write_limit(5'd0);
    send_word(random_word(CMD_INSERT));
    send_word(random_word(CMD_INSERT));
    send_word(random_word(CMD_POP));
    send_word(random_word(CMD_POP));
    drain();
    write_limit(5'd2);
    send_word(random_word(CMD_INSERT));
    send_word(random_word(CMD_INSERT));
    drain();
    write_limit(5'd1);
    send_word(random_word(CMD_INSERT));
    send_word(random_word(CMD_POP));
    send_word(random_word(CMD_INSERT));
    send_word(random_word(CMD_POP));
    send_word(random_word(CMD_INSERT));
    send_word(random_word(CMD_POP));
    drain();
  endtask

  // fill and drain bursts with random content over several limits
  task automatic test_random_traffic;
    logic [CAP_W-1:0] limits[8];
    int fill_pct;
    int burst_left;
    limits = '{5'd16, 5'd31, 5'd1, 5'd5, 5'd0, 5'd17, 5'd8, 5'd3};
    for (int ph = 0; ph < 8; ph++) begin
      write_limit(limits[ph]);
      set_idle_profile(ph);
      burst_left = 0;
      fill_pct = 75;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(10, 40);
          fill_pct = (fill_pct > 50) ? 25 : 75;
          if ($urandom_range(0, 9) == 0) fill_pct = 50;
        end
        burst_left--;
        send_word(random_word(($urandom_range(0, 99) < fill_pct) ? CMD_INSERT : CMD_POP));
      end
      drain();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_extremes();
    test_limit_edges();
    test_random_traffic();
    $display("covered %0d inserts, %0d pops, %0d full rejects, %0d empty pops",
             n_inserted, n_popped, n_full, n_empty);
    $display("limits 0, 1, 2, 3, 5, 8, 16, 17, 31 under four idle and stall profiles");
    if (err_count == 0) begin
      $display("[stable_bounded_priority_queue_core] OK");
    end else begin
      $display("[stable_bounded_priority_queue_core] ERROR");
    end
    $finish;
  end

endmodule

@@ stable_bounded_priority_queue_core.f @@
+incdir+rtl/core
rtl/core/sbpq_pkg.sv
rtl/core/sbpq_cell.sv
rtl/core/stable_bounded_priority_queue_core.sv
rtl/core/sbpq_checker.sv
dv/tb.sv
